@@ rtl/masked_monomial_regression_eval_macros.svh @@
// ----------------------------------------------------------------------------
// masked monomial regression evaluator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef MASKED_MONOMIAL_REGRESSION_EVAL_MACROS_SVH
`define MASKED_MONOMIAL_REGRESSION_EVAL_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define MMRE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define MMRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mmre_pkg.sv @@
// ----------------------------------------------------------------------------
// mmre_pkg
// types and constants shared by the regression evaluator files
// ----------------------------------------------------------------------------
package mmre_pkg;

    localparam int NUM_FACTORS = 10;

    // item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // configuration register indexes
    localparam logic CFG_INTERCEPT  = 1'b0;
    localparam logic CFG_TERM_COUNT = 1'b1;

    // shared unit operations
    localparam logic FOP_MUL = 1'b0;
    localparam logic FOP_ADD = 1'b1;

    localparam logic [63:0] DBL_ONE     = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DBL_ZERO    = 64'h0000_0000_0000_0000;
    localparam logic [63:0] DBL_DEF_NAN = 64'hFFF8_0000_0000_0000;

    typedef struct packed {
        logic        op;
        logic [5:0]  term_index;
        logic [9:0]  term_mask;
        logic [63:0] coefficient;
        logic [63:0] coord_x;
        logic [63:0] coord_y;
        logic [63:0] elevation;
        logic [63:0] exposition;
        logic [63:0] shore_distance;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic        op;
        logic [63:0] a;
        logic [63:0] b;
    } t_fpu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_fpu_rsp;

endpackage

@@ rtl/mmre_ifs.sv @@
// ----------------------------------------------------------------------------
// mmre channel interfaces
// input item, result item and configuration write channels
// ----------------------------------------------------------------------------
interface mmre_in_if import mmre_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mmre_out_if import mmre_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mmre_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [63:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/mmre_fpu.sv @@
// ----------------------------------------------------------------------------
// mmre_fpu
// multi-cycle double precision multiply / add unit, round to nearest even
// ----------------------------------------------------------------------------
module mmre_fpu import mmre_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_fpu_req i_req,
    output t_fpu_rsp o_rsp
);

    localparam logic [2:0] F_IDLE   = 3'd0;
    localparam logic [2:0] F_MUL    = 3'd1;
    localparam logic [2:0] F_ALIGN  = 3'd2;
    localparam logic [2:0] F_ADDSUB = 3'd3;
    localparam logic [2:0] F_NORM   = 3'd4;
    localparam logic [2:0] F_ROUND  = 3'd5;
    localparam logic [2:0] F_DONE   = 3'd6;

    function automatic logic [107:0] shr_sticky(input logic [107:0] v,
                                                input logic [13:0] amt);
        logic [107:0] msk;
        logic         lost;
        logic [6:0]   sh;
        if (amt >= 14'd108) begin
            return {107'b0, |v};
        end
        sh   = amt[6:0];
        msk  = ~({108{1'b1}} << sh);
        lost = |(v & msk);
        return (v >> sh) | {107'b0, lost};
    endfunction

    logic [2:0]          r_st;
    logic                r_sa;
    logic                r_sb;
    logic                r_sr;
    logic [10:0]         r_ea;
    logic [10:0]         r_eb;
    logic [52:0]         r_ma;
    logic [52:0]         r_mb;
    logic [107:0]        r_m;
    logic [107:0]        r_bm;
    logic signed [13:0]  r_e;
    logic [2:0]          r_cnt;
    logic [53:0]         r_pp;
    logic                r_subn;
    logic [63:0]         r_res;

    // operand unpack
    logic        a_s, b_s;
    logic [10:0] a_x, b_x, a_eff, b_eff;
    logic [51:0] a_f, b_f;
    logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
    logic [52:0] a_man, b_man;
    logic        spec_hit;
    logic [63:0] spec_res;

    assign a_s    = i_req.a[63];
    assign b_s    = i_req.b[63];
    assign a_x    = i_req.a[62:52];
    assign b_x    = i_req.b[62:52];
    assign a_f    = i_req.a[51:0];
    assign b_f    = i_req.b[51:0];
    assign a_zero = (a_x == 11'd0) && (a_f == 52'd0);
    assign b_zero = (b_x == 11'd0) && (b_f == 52'd0);
    assign a_inf  = (a_x == 11'h7FF) && (a_f == 52'd0);
    assign b_inf  = (b_x == 11'h7FF) && (b_f == 52'd0);
    assign a_nan  = (a_x == 11'h7FF) && (a_f != 52'd0);
    assign b_nan  = (b_x == 11'h7FF) && (b_f != 52'd0);
    assign a_man  = {a_x != 11'd0, a_f};
    assign b_man  = {b_x != 11'd0, b_f};
    assign a_eff  = (a_x == 11'd0) ? 11'd1 : a_x;
    assign b_eff  = (b_x == 11'd0) ? 11'd1 : b_x;

    // nan, infinity and zero results that skip the datapath
    always_comb begin
        spec_hit = 1'b1;
        spec_res = DBL_DEF_NAN;
        if (a_nan) begin
            spec_res = i_req.a | 64'h0008_0000_0000_0000;
        end else if (b_nan) begin
            spec_res = i_req.b | 64'h0008_0000_0000_0000;
        end else if (i_req.op == FOP_MUL) begin
            if ((a_inf && b_zero) || (b_inf && a_zero)) begin
                spec_res = DBL_DEF_NAN;
            end else if (a_inf || b_inf) begin
                spec_res = {a_s ^ b_s, 11'h7FF, 52'd0};
            end else if (a_zero || b_zero) begin
                spec_res = {a_s ^ b_s, 63'd0};
            end else begin
                spec_hit = 1'b0;
            end
        end else begin
            if (a_inf && b_inf && (a_s != b_s)) begin
                spec_res = DBL_DEF_NAN;
            end else if (a_inf) begin
                spec_res = i_req.a;
            end else if (b_inf) begin
                spec_res = i_req.b;
            end else begin
                spec_hit = 1'b0;
            end
        end
    end

    // one 27x27 partial product per cycle
    logic [26:0]  mul_x, mul_y;
    logic [53:0]  mul_pp;
    logic [107:0] acc_add;

    always_comb begin
        mul_x = ((r_cnt == 3'd2) || (r_cnt == 3'd3)) ? {1'b0, r_ma[52:27]} : r_ma[26:0];
        mul_y = ((r_cnt == 3'd1) || (r_cnt == 3'd3)) ? {1'b0, r_mb[52:27]} : r_mb[26:0];
    end
    assign mul_pp = 54'(mul_x) * 54'(mul_y);

    always_comb begin
        case (r_cnt)
            3'd1:    acc_add = 108'(r_pp);
            3'd2:    acc_add = 108'(r_pp) << 27;
            3'd3:    acc_add = 108'(r_pp) << 27;
            3'd4:    acc_add = 108'(r_pp) << 54;
            default: acc_add = 108'd0;
        endcase
    end

    // add path
    logic [107:0] add_a, add_b0;
    logic [108:0] sum_ab;
    logic [107:0] dif_ab, dif_ba;
    logic         a_ge_b;

    assign add_a  = {2'b0, r_ma, 53'b0};
    assign add_b0 = {2'b0, r_mb, 53'b0};
    assign sum_ab = {1'b0, r_m} + {1'b0, r_bm};
    assign dif_ab = r_m - r_bm;
    assign dif_ba = r_bm - r_m;
    assign a_ge_b = (r_m >= r_bm);

    // normalize and round
    logic signed [13:0] norm_be;
    logic               rnd_up;
    logic [53:0]        rnd_sum;
    logic signed [13:0] rnd_exp;

    assign norm_be = r_e + 14'sd1130;
    assign rnd_up  = r_m[54] & ((|r_m[53:0]) | r_m[55]);
    assign rnd_sum = {1'b0, r_m[107:55]} + 54'(rnd_up);
    assign rnd_exp = r_subn ? $signed({13'd0, rnd_sum[52]})
                            : r_e + $signed({13'd0, rnd_sum[53]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= F_IDLE;
        end else begin
            case (r_st)
                F_IDLE: begin
                    if (i_req.start) begin
                        if (spec_hit) begin
                            r_res <= spec_res;
                            r_st  <= F_DONE;
                        end else if (i_req.op == FOP_MUL) begin
                            r_ma  <= a_man;
                            r_mb  <= b_man;
                            r_sr  <= a_s ^ b_s;
                            r_e   <= $signed({3'b0, a_eff}) + $signed({3'b0, b_eff})
                                     - 14'sd2150;
                            r_m   <= 108'd0;
                            r_cnt <= 3'd0;
                            r_st  <= F_MUL;
                        end else begin
                            // larger exponent goes to the a side
                            if (b_eff > a_eff) begin
                                r_sa <= b_s;  r_sb <= a_s;
                                r_ea <= b_eff; r_eb <= a_eff;
                                r_ma <= b_man; r_mb <= a_man;
                            end else begin
                                r_sa <= a_s;  r_sb <= b_s;
                                r_ea <= a_eff; r_eb <= b_eff;
                                r_ma <= a_man; r_mb <= b_man;
                            end
                            r_st <= F_ALIGN;
                        end
                    end
                end
                F_MUL: begin
                    if (r_cnt != 3'd4) begin
                        r_pp <= mul_pp;
                    end
                    if (r_cnt != 3'd0) begin
                        r_m <= r_m + acc_add;
                    end
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd4) begin
                        r_st <= F_NORM;
                    end
                end
                F_ALIGN: begin
                    r_m  <= add_a;
                    r_bm <= shr_sticky(add_b0, {3'b0, r_ea - r_eb});
                    r_e  <= $signed({3'b0, r_ea}) - 14'sd1128;
                    r_st <= F_ADDSUB;
                end
                F_ADDSUB: begin
                    if (r_sa == r_sb) begin
                        if (sum_ab == 109'd0) begin
                            r_res <= {r_sa & r_sb, 63'd0};
                            r_st  <= F_DONE;
                        end else begin
                            r_m  <= sum_ab[107:0];
                            r_sr <= r_sa;
                            r_st <= F_NORM;
                        end
                    end else if (r_m == r_bm) begin
                        // exact cancellation gives +0
                        r_res <= {r_sa & r_sb, 63'd0};
                        r_st  <= F_DONE;
                    end else if (a_ge_b) begin
                        r_m  <= dif_ab;
                        r_sr <= r_sa;
                        r_st <= F_NORM;
                    end else begin
                        r_m  <= dif_ba;
                        r_sr <= r_sb;
                        r_st <= F_NORM;
                    end
                end
                F_NORM: begin
                    if (r_m[107:92] == 16'd0) begin
                        r_m <= r_m << 16;
                        r_e <= r_e - 14'sd16;
                    end else if (r_m[107:104] == 4'd0) begin
                        r_m <= r_m << 4;
                        r_e <= r_e - 14'sd4;
                    end else if (!r_m[107]) begin
                        r_m <= r_m << 1;
                        r_e <= r_e - 14'sd1;
                    end else begin
                        // below the normal range the result goes subnormal
                        if (norm_be < 14'sd1) begin
                            r_m    <= shr_sticky(r_m, 14'(14'sd1 - norm_be));
                            r_subn <= 1'b1;
                        end else begin
                            r_subn <= 1'b0;
                        end
                        r_e  <= norm_be;
                        r_st <= F_ROUND;
                    end
                end
                F_ROUND: begin
                    if (!r_subn && (rnd_exp >= 14'sd2047)) begin
                        r_res <= {r_sr, 11'h7FF, 52'd0};
                    end else begin
                        r_res <= {r_sr, rnd_exp[10:0], rnd_sum[51:0]};
                    end
                    r_st <= F_DONE;
                end
                F_DONE: begin
                    r_st <= F_IDLE;
                end
                default: begin
                    r_st <= F_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = (r_st == F_DONE);
    assign o_rsp.res  = r_res;

endmodule

@@ rtl/masked_monomial_regression_eval.sv @@
// ----------------------------------------------------------------------------
// masked_monomial_regression_eval
// term table plus a shared double multiply / add unit evaluating
// intercept + sum of coefficient * selected coordinate factors
// ----------------------------------------------------------------------------
// channel      dir  handshake     payload
// i_in_chan    in   valid/ready   op, term_index, term_mask, coefficient, coords
// o_out_chan   out  valid/ready   value
// i_cfg_chan   in   valid/ready   index (0 intercept, 1 term_count), wdata
//
// a load item is taken while idle and writes the term table; an evaluate item runs
// 5 squaring multiplies, then per term a table read (S_TRD, S_TLD), a scan of the
// 10 mask bits, a multiply per selected bit, one by the coefficient and one add,
// all on the one fpu, whose special operand cases skip its datapath.
// reset is synchronous; input ready is low while an evaluate runs; a finished
// value waits in the output register, and loads are still taken while it waits.
// ----------------------------------------------------------------------------
module masked_monomial_regression_eval import mmre_pkg::*; #(
    parameter int MAX_TERMS = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    mmre_in_if.sink    i_in_chan,
    mmre_out_if.source o_out_chan,
    mmre_cfg_if.sink   i_cfg_chan
);

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;
    localparam logic [3:0] S_SQW   = 4'd2;
    localparam logic [3:0] S_TRD   = 4'd3;
    localparam logic [3:0] S_TLD   = 4'd4;
    localparam logic [3:0] S_FAC   = 4'd5;
    localparam logic [3:0] S_FACW  = 4'd6;
    localparam logic [3:0] S_PMUL  = 4'd7;
    localparam logic [3:0] S_PMULW = 4'd8;
    localparam logic [3:0] S_ADD   = 4'd9;
    localparam logic [3:0] S_ADDW  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic        in_valid, in_ready, in_op, in_fire;
    logic        out_valid, out_ready;
    t_in_item    in_item;

    logic [3:0]  r_st;
    logic [63:0] r_intercept;
    logic [6:0]  r_term_count;
    logic [6:0]  r_n;
    logic [6:0]  r_i;
    logic [3:0]  r_k;
    logic [63:0] r_fac [NUM_FACTORS];
    logic [9:0]  r_mask;
    logic [63:0] r_coef;
    logic [63:0] r_e;
    logic [63:0] r_f;
    logic        r_out_valid;
    logic [63:0] r_out_value;

    // term table
    logic [9:0]  mask_mem [MAX_TERMS];
    logic [63:0] coef_mem [MAX_TERMS];
    logic [9:0]  r_mask_rd;
    logic [63:0] r_coef_rd;
    logic        mem_we;
    logic [AW-1:0] wr_addr, rd_addr;

    t_fpu_req fpu_req;
    t_fpu_rsp fpu_rsp;
    logic [6:0] n_use;

    assign in_valid  = i_in_chan.valid;
    assign in_item   = i_in_chan.data;
    assign in_op     = in_item.op;
    assign in_ready  = (r_st == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = r_out_valid;
    assign out_ready = o_out_chan.ready;

    assign i_in_chan.ready        = in_ready;
    assign o_out_chan.valid       = r_out_valid;
    assign o_out_chan.data.value  = r_out_value;
    assign i_cfg_chan.ready       = 1'b1;

    assign mem_we  = in_fire && (in_op == OP_LOAD) && (32'(in_item.term_index) < MAX_TERMS);
    assign wr_addr = AW'(in_item.term_index);
    assign rd_addr = AW'(r_i);
    // counts above the table saturate
    assign n_use   = (32'(r_term_count) > MAX_TERMS) ? 7'(MAX_TERMS) : r_term_count;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mask_mem[wr_addr] <= in_item.term_mask;
            coef_mem[wr_addr] <= in_item.coefficient;
        end
        r_mask_rd <= mask_mem[rd_addr];
        r_coef_rd <= coef_mem[rd_addr];
    end

    mmre_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .o_rsp   (fpu_rsp)
    );

    always_comb begin
        fpu_req = '0;
        case (r_st)
            S_SQ: begin
                fpu_req.start = 1'b1;
                fpu_req.op    = FOP_MUL;
                fpu_req.a     = r_fac[r_k];
                fpu_req.b     = r_fac[r_k];
            end
            S_FAC: begin
                fpu_req.start = (r_k != 4'd10) && r_mask[r_k];
                fpu_req.op    = FOP_MUL;
                fpu_req.a     = r_e;
                fpu_req.b     = r_fac[r_k];
            end
            S_PMUL: begin
                fpu_req.start = 1'b1;
                fpu_req.op    = FOP_MUL;
                fpu_req.a     = r_e;
                fpu_req.b     = r_coef;
            end
            S_ADD: begin
                fpu_req.start = 1'b1;
                fpu_req.op    = FOP_ADD;
                fpu_req.a     = r_f;
                fpu_req.b     = r_e;
            end
            default: begin
                fpu_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= S_IDLE;
            r_intercept  <= DBL_ZERO;
            r_term_count <= 7'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_chan.valid) begin
                if (i_cfg_chan.index == CFG_INTERCEPT) begin
                    r_intercept <= i_cfg_chan.wdata;
                end else begin
                    r_term_count <= i_cfg_chan.wdata[6:0];
                end
            end
            if ((r_st == S_FIN) && (!r_out_valid || out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (in_fire && (in_op == OP_EVAL)) begin
                        r_fac[0] <= in_item.coord_x;
                        r_fac[1] <= in_item.coord_y;
                        r_fac[2] <= in_item.elevation;
                        r_fac[3] <= in_item.exposition;
                        r_fac[4] <= in_item.shore_distance;
                        r_n      <= n_use;
                        r_i      <= 7'd0;
                        r_k      <= 4'd0;
                        r_f      <= (n_use == 7'd0) ? DBL_ZERO : r_intercept;
                        if (n_use == 7'd0) begin
                            r_st <= S_FIN;
                        end else begin
                            r_st <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    r_st <= S_SQW;
                end
                S_SQW: begin
                    if (fpu_rsp.done) begin
                        r_fac[r_k + 4'd5] <= fpu_rsp.res;
                        r_k <= r_k + 4'd1;
                        r_st <= (r_k == 4'd4) ? S_TRD : S_SQ;
                    end
                end
                S_TRD: begin
                    r_st <= S_TLD;
                end
                S_TLD: begin
                    r_mask <= r_mask_rd;
                    r_coef <= r_coef_rd;
                    // an empty mask starts the product at zero instead of one
                    r_e    <= (r_mask_rd == 10'd0) ? DBL_ZERO : DBL_ONE;
                    r_k    <= 4'd0;
                    r_st   <= S_FAC;
                end
                S_FAC: begin
                    if (r_k == 4'd10) begin
                        r_st <= S_PMUL;
                    end else if (r_mask[r_k]) begin
                        r_st <= S_FACW;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_FACW: begin
                    if (fpu_rsp.done) begin
                        r_e  <= fpu_rsp.res;
                        r_k  <= r_k + 4'd1;
                        r_st <= S_FAC;
                    end
                end
                S_PMUL: begin
                    r_st <= S_PMULW;
                end
                S_PMULW: begin
                    if (fpu_rsp.done) begin
                        r_e  <= fpu_rsp.res;
                        r_st <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_st <= S_ADDW;
                end
                S_ADDW: begin
                    if (fpu_rsp.done) begin
                        r_f <= fpu_rsp.res;
                        if (r_i + 7'd1 == r_n) begin
                            r_st <= S_FIN;
                        end else begin
                            r_i  <= r_i + 7'd1;
                            r_st <= S_TRD;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || out_ready) begin
                        r_out_value <= r_f;
                        r_st        <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/mmre_chk.sv @@
// ----------------------------------------------------------------------------
// mmre_chk
// port-level checks on the regression evaluator, bound to the top level
// ----------------------------------------------------------------------------
`include "masked_monomial_regression_eval_macros.svh"

module mmre_chk import mmre_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_op,
    input logic i_out_valid,
    input logic i_out_ready
);

    `MMRE_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result item dropped while stalled")
    `MMRE_ASSERT_NEXT(a_load_silent, i_in_valid && i_in_ready && (i_in_op == OP_LOAD) && !i_out_valid, !i_out_valid, "load item produced a result")
    `MMRE_ASSERT_NEXT(a_eval_busy, i_in_valid && i_in_ready && (i_in_op == OP_EVAL), !i_in_ready, "input still ready after evaluate item")
    `MMRE_ASSERT_NOW(a_out_from_busy, $rose(i_out_valid), $past(!i_in_ready), "result appeared without a running evaluate")

endmodule

bind masked_monomial_regression_eval mmre_chk u_mmre_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (in_valid),
    .i_in_ready  (in_ready),
    .i_in_op     (in_op),
    .i_out_valid (out_valid),
    .i_out_ready (out_ready)
);
